[hw/rtl/rtbd_pkg.sv]
package rtbd_pkg;

	// Field widths of the item formats.
	localparam int SCORE_W = 16;
	localparam int DIST_W  = 16;
	localparam int ANGLE_W = 16;
	localparam int POS_W   = 8;
	localparam int SIZE_W  = 17;
	localparam int CENTER_W = 20;
	localparam int DEG_W   = 16;
	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 112;

	// Internal datapath widths: x and y hold Q.30 values near one, z a Q.30 angle.
	localparam int XY_W = 33;
	localparam int Z_W  = 34;
	localparam int DIFF_W = 17;
	localparam int PROD_W = 50;
	localparam int DEGP_W = 41;

	// Cells at or beyond this column or row are dropped.
	localparam int unsigned MAP_SIZE_MAX = 256;

	// Number of entries in the arctangent table.
	localparam int ATAN_ENTRIES = 24;

	// Fixed-point constants.
	localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;
	localparam logic signed [Z_W-1:0]  PI_Q30          = 34'sd3373259426;
	localparam logic signed [Z_W-1:0]  HALF_PI_Q30     = 34'sd1686629713;
	localparam logic signed [23:0]     DEG_PER_RAD_Q16 = 24'sd3754936;
	localparam logic [15:0]            THRESHOLD_RESET = 16'd32768;

	// One input item after unpacking.
	typedef struct packed {
		logic [SCORE_W-1:0]        cell_score;
		logic [DIST_W-1:0]         dist_top;
		logic [DIST_W-1:0]         dist_right;
		logic [DIST_W-1:0]         dist_bottom;
		logic [DIST_W-1:0]         dist_left;
		logic signed [ANGLE_W-1:0] box_angle;
		logic [POS_W-1:0]          cell_col;
		logic [POS_W-1:0]          cell_row;
	} in_item_t;

	// Rotation state that walks through the CORDIC stages.
	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic                   flip;
	} cord_t;

	// Values that ride alongside the rotation state.
	typedef struct packed {
		logic [SIZE_W-1:0]          box_width;
		logic [SIZE_W-1:0]          box_height;
		logic signed [DIFF_W-1:0]   diff_rl;
		logic signed [DIFF_W-1:0]   diff_bt;
		logic [SCORE_W-1:0]         score;
		logic signed [DEGP_W-1:0]   deg_prod;
		logic [POS_W-1:0]           cell_col;
		logic [POS_W-1:0]           cell_row;
	} side_t;

	// One result item before packing.
	typedef struct packed {
		logic signed [CENTER_W-1:0] center_x;
		logic signed [CENTER_W-1:0] center_y;
		logic [SIZE_W-1:0]          box_width;
		logic [SIZE_W-1:0]          box_height;
		logic signed [DEG_W-1:0]    angle_degrees;
		logic [SCORE_W-1:0]         box_score;
	} out_item_t;

	// Arctangent of 2^-idx in Q.30.
	function automatic logic [29:0] atan_q30(input logic [4:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:  v = 30'd843314857;
			5'd1:  v = 30'd497837829;
			5'd2:  v = 30'd263043837;
			5'd3:  v = 30'd133525159;
			5'd4:  v = 30'd67021687;
			5'd5:  v = 30'd33543516;
			5'd6:  v = 30'd16775851;
			5'd7:  v = 30'd8388437;
			5'd8:  v = 30'd4194283;
			5'd9:  v = 30'd2097149;
			5'd10: v = 30'd1048576;
			5'd11: v = 30'd524288;
			5'd12: v = 30'd262144;
			5'd13: v = 30'd131072;
			5'd14: v = 30'd65536;
			5'd15: v = 30'd32768;
			5'd16: v = 30'd16384;
			5'd17: v = 30'd8192;
			5'd18: v = 30'd4096;
			5'd19: v = 30'd2048;
			5'd20: v = 30'd1024;
			5'd21: v = 30'd512;
			5'd22: v = 30'd256;
			5'd23: v = 30'd128;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

[hw/rtl/rtbd_front.sv]
module rtbd_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wen,
	input  logic [15:0]             cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  rtbd_pkg::in_item_t      in_item,
	output logic                    out_valid,
	input  logic                    out_ready,
	output rtbd_pkg::cord_t         out_cord,
	output rtbd_pkg::side_t         out_side
);

	logic [15:0]             thr_q;
	logic                    vld_s1;
	rtbd_pkg::cord_t         cord_s1;
	rtbd_pkg::side_t         side_s1;
	logic                    keep;
	logic signed [rtbd_pkg::Z_W-1:0] z_raw;
	rtbd_pkg::cord_t         cord_d;
	rtbd_pkg::side_t         side_d;

	// Score threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= rtbd_pkg::THRESHOLD_RESET;
		end else if (cfg_wen) begin
			thr_q <= cfg_wdata;
		end
	end

	// A cell is kept when its score reaches the threshold and it lies inside the map.
	assign keep = (in_item.cell_score >= thr_q)
		&& (32'(in_item.cell_col) < rtbd_pkg::MAP_SIZE_MAX)
		&& (32'(in_item.cell_row) < rtbd_pkg::MAP_SIZE_MAX);

	// Widen the angle to Q.30 and fold it into the half plane around zero.
	assign z_raw = {in_item.box_angle[15], in_item.box_angle, 17'd0};

	always_comb begin
		cord_d.x = rtbd_pkg::CORDIC_GAIN_Q30;
		cord_d.y = '0;
		if (z_raw > rtbd_pkg::HALF_PI_Q30) begin
			cord_d.z    = z_raw - rtbd_pkg::PI_Q30;
			cord_d.flip = 1'b1;
		end else if (z_raw < -rtbd_pkg::HALF_PI_Q30) begin
			cord_d.z    = z_raw + rtbd_pkg::PI_Q30;
			cord_d.flip = 1'b1;
		end else begin
			cord_d.z    = z_raw;
			cord_d.flip = 1'b0;
		end
	end

	// Box size, edge differences and the degree product.
	always_comb begin
		side_d.box_width  = 17'(in_item.dist_right) + 17'(in_item.dist_left);
		side_d.box_height = 17'(in_item.dist_top) + 17'(in_item.dist_bottom);
		side_d.diff_rl    = $signed(17'(in_item.dist_right)) - $signed(17'(in_item.dist_left));
		side_d.diff_bt    = $signed(17'(in_item.dist_bottom)) - $signed(17'(in_item.dist_top));
		side_d.score      = in_item.cell_score;
		side_d.deg_prod   = in_item.box_angle * rtbd_pkg::DEG_PER_RAD_Q16;
		side_d.cell_col   = in_item.cell_col;
		side_d.cell_row   = in_item.cell_row;
	end

	assign in_ready = !vld_s1 || out_ready;

	// Stage valid bit; dropped cells leave a bubble.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cord_s1 <= cord_d;
			side_s1 <= side_d;
		end
	end

	assign out_valid = vld_s1;
	assign out_cord  = cord_s1;
	assign out_side  = side_s1;

endmodule

[hw/rtl/rtbd_cordic_step.sv]
module rtbd_cordic_step #(
	parameter int STEP = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rtbd_pkg::cord_t  in_cord,
	input  rtbd_pkg::side_t  in_side,
	output logic             out_valid,
	input  logic             out_ready,
	output rtbd_pkg::cord_t  out_cord,
	output rtbd_pkg::side_t  out_side
);

	logic                    vld_s1;
	rtbd_pkg::cord_t         cord_s1;
	rtbd_pkg::side_t         side_s1;
	rtbd_pkg::cord_t         cord_d;
	logic signed [rtbd_pkg::XY_W-1:0] dx;
	logic signed [rtbd_pkg::XY_W-1:0] dy;
	logic signed [rtbd_pkg::Z_W-1:0]  atan_v;

	// One rotation: shifts floor toward minus infinity.
	assign dx     = in_cord.y >>> STEP;
	assign dy     = in_cord.x >>> STEP;
	assign atan_v = $signed({4'd0, rtbd_pkg::atan_q30(5'(STEP))});

	always_comb begin
		cord_d.flip = in_cord.flip;
		if (in_cord.z >= 0) begin
			cord_d.x = in_cord.x - dx;
			cord_d.y = in_cord.y + dy;
			cord_d.z = in_cord.z - atan_v;
		end else begin
			cord_d.x = in_cord.x + dx;
			cord_d.y = in_cord.y - dy;
			cord_d.z = in_cord.z + atan_v;
		end
	end

	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cord_s1 <= cord_d;
			side_s1 <= in_side;
		end
	end

	assign out_valid = vld_s1;
	assign out_cord  = cord_s1;
	assign out_side  = side_s1;

endmodule

[hw/rtl/rtbd_center.sv]
module rtbd_center #(
	parameter int CELL_STRIDE = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rtbd_pkg::cord_t      in_cord,
	input  rtbd_pkg::side_t      in_side,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rtbd_pkg::out_item_t  out_item
);

	localparam int OFF_W = rtbd_pkg::POS_W + $clog2(CELL_STRIDE + 1) + 5;
	localparam int SUM_W = ((OFF_W + 1 > rtbd_pkg::CENTER_W) ? OFF_W + 1 : rtbd_pkg::CENTER_W) + 1;
	localparam int ACC_W = rtbd_pkg::PROD_W + 1;
	localparam logic signed [SUM_W-1:0] CMAX = SUM_W'(524287);
	localparam logic signed [SUM_W-1:0] CMIN = SUM_W'(-524288);
	localparam logic signed [ACC_W-1:0] HALF_Q31 = ACC_W'(1073741824);
	localparam logic signed [rtbd_pkg::DEGP_W-1:0] HALF_Q22 = 41'sd2097152;
	localparam logic signed [18:0] DMAX = 19'sd32767;
	localparam logic signed [18:0] DMIN = -19'sd32768;

	logic                                   vld_s1, vld_s2, vld_s3;
	logic                                   rdy_s1, rdy_s2, rdy_s3;
	logic signed [rtbd_pkg::PROD_W-1:0]     pxa_s1, pyb_s1, pxb_s1, pya_s1;
	rtbd_pkg::side_t                        side_s1, side_s2;
	logic signed [rtbd_pkg::CENTER_W-1:0]   shx_s2, shy_s2;
	logic signed [18:0]                     deg_s2;
	rtbd_pkg::out_item_t                    item_s3;
	logic signed [rtbd_pkg::DIFF_W-1:0]     a_sgn, b_sgn;
	logic signed [ACC_W-1:0]                acc_x, acc_y;
	logic signed [rtbd_pkg::DEGP_W-1:0]     deg_acc;
	logic [OFF_W-1:0]                       off_x, off_y;
	logic signed [SUM_W-1:0]                cx_full, cy_full;

	// Ready chain: a stage takes an item when empty or when it moves on.
	assign rdy_s3   = !vld_s3 || out_ready;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= in_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	// Stage 1: fold the sign of cos and sin into the edge differences, then multiply.
	assign a_sgn = in_cord.flip ? -in_side.diff_rl : in_side.diff_rl;
	assign b_sgn = in_cord.flip ? -in_side.diff_bt : in_side.diff_bt;

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			pxa_s1  <= in_cord.x * a_sgn;
			pyb_s1  <= in_cord.y * b_sgn;
			pxb_s1  <= in_cord.x * b_sgn;
			pya_s1  <= in_cord.y * a_sgn;
			side_s1 <= in_side;
		end
	end

	// Stage 2: sum the rotated offsets and round to Q.5; round the degrees.
	assign acc_x   = ACC_W'(pxa_s1) + ACC_W'(pyb_s1) + HALF_Q31;
	assign acc_y   = ACC_W'(pxb_s1) - ACC_W'(pya_s1) + HALF_Q31;
	assign deg_acc = HALF_Q22 - side_s1.deg_prod;

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			shx_s2  <= acc_x[ACC_W-1:31];
			shy_s2  <= acc_y[ACC_W-1:31];
			deg_s2  <= deg_acc[rtbd_pkg::DEGP_W-1:22];
			side_s2 <= side_s1;
		end
	end

	// Stage 3: add the cell origin and saturate.
	assign off_x   = OFF_W'(32'(side_s2.cell_col) * CELL_STRIDE * 32);
	assign off_y   = OFF_W'(32'(side_s2.cell_row) * CELL_STRIDE * 32);
	assign cx_full = $signed(SUM_W'(off_x)) + SUM_W'(shx_s2);
	assign cy_full = $signed(SUM_W'(off_y)) + SUM_W'(shy_s2);

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			if (cx_full > CMAX) begin
				item_s3.center_x <= rtbd_pkg::CENTER_W'(CMAX);
			end else if (cx_full < CMIN) begin
				item_s3.center_x <= rtbd_pkg::CENTER_W'(CMIN);
			end else begin
				item_s3.center_x <= rtbd_pkg::CENTER_W'(cx_full);
			end
			if (cy_full > CMAX) begin
				item_s3.center_y <= rtbd_pkg::CENTER_W'(CMAX);
			end else if (cy_full < CMIN) begin
				item_s3.center_y <= rtbd_pkg::CENTER_W'(CMIN);
			end else begin
				item_s3.center_y <= rtbd_pkg::CENTER_W'(cy_full);
			end
			if (deg_s2 > DMAX) begin
				item_s3.angle_degrees <= 16'(DMAX);
			end else if (deg_s2 < DMIN) begin
				item_s3.angle_degrees <= 16'(DMIN);
			end else begin
				item_s3.angle_degrees <= 16'(deg_s2);
			end
			item_s3.box_width  <= side_s2.box_width;
			item_s3.box_height <= side_s2.box_height;
			item_s3.box_score  <= side_s2.score;
		end
	end

	assign out_valid = vld_s3;
	assign out_item  = item_s3;

endmodule

[hw/rtl/rotated_text_box_decode.sv]
// Rotated text box decoder for a text-detector feature map.
// The slave stream takes one cell per item; the block drops cells whose score
// is below the threshold register and decodes the others into one rotated box
// on the master stream. Cells may arrive in every cycle: one item per cycle
// is sustained while the receiver accepts, with no dependence between cells.
// An accepted cell passes one front stage, one stage per CORDIC rotation
// (16 at the default of 16 steps), and three stages of multiply, round and
// saturate on its way to its box.
// The number of CORDIC stages is the smaller of CORDIC_STEPS and 24.
// cfg_wen writes cfg_wdata into the score threshold; write it only while the
// pipeline is empty.
// Reset empties the pipeline and sets the threshold to 0.5 (32768).
// When the receiver stalls, each stage holds its item; empty stages keep
// filling, so s_tready drops only once every stage holds an item.
module rotated_text_box_decode #(
	parameter int CELL_STRIDE  = 4,
	parameter int CORDIC_STEPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wen,
	input  logic [15:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// cell_score, dist_top, dist_right, dist_bottom, dist_left, box_angle,
	// cell_col, cell_row (from bit 0 up)
	input  logic [rtbd_pkg::IN_DATA_W-1:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// center_x, center_y, box_width, box_height, angle_degrees, box_score
	// (from bit 0 up), six zero bits on top
	output logic [rtbd_pkg::OUT_DATA_W-1:0] m_tdata
);

	localparam int NSTEPS = (CORDIC_STEPS < rtbd_pkg::ATAN_ENTRIES) ?
		CORDIC_STEPS : rtbd_pkg::ATAN_ENTRIES;

	rtbd_pkg::in_item_t  in_item;
	rtbd_pkg::out_item_t out_item;
	rtbd_pkg::cord_t     chain_cord [NSTEPS+1];
	rtbd_pkg::side_t     chain_side [NSTEPS+1];
	logic                chain_vld  [NSTEPS+1];
	logic                chain_rdy  [NSTEPS+1];

	// Unpack the input item.
	assign in_item.cell_score  = s_tdata[15:0];
	assign in_item.dist_top    = s_tdata[31:16];
	assign in_item.dist_right  = s_tdata[47:32];
	assign in_item.dist_bottom = s_tdata[63:48];
	assign in_item.dist_left   = s_tdata[79:64];
	assign in_item.box_angle   = s_tdata[95:80];
	assign in_item.cell_col    = s_tdata[103:96];
	assign in_item.cell_row    = s_tdata[111:104];

	rtbd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.out_valid (chain_vld[0]),
		.out_ready (chain_rdy[0]),
		.out_cord  (chain_cord[0]),
		.out_side  (chain_side[0])
	);

	// One pipeline stage per CORDIC rotation.
	for (genvar i = 0; i < NSTEPS; i++) begin : g_step
		rtbd_cordic_step #(
			.STEP (i)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_vld[i]),
			.in_ready  (chain_rdy[i]),
			.in_cord   (chain_cord[i]),
			.in_side   (chain_side[i]),
			.out_valid (chain_vld[i+1]),
			.out_ready (chain_rdy[i+1]),
			.out_cord  (chain_cord[i+1]),
			.out_side  (chain_side[i+1])
		);
	end

	rtbd_center #(
		.CELL_STRIDE (CELL_STRIDE)
	) u_center (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_vld[NSTEPS]),
		.in_ready  (chain_rdy[NSTEPS]),
		.in_cord   (chain_cord[NSTEPS]),
		.in_side   (chain_side[NSTEPS]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (out_item)
	);

	// Pack the result item.
	assign m_tdata = {6'd0, out_item.box_score, out_item.angle_degrees,
		out_item.box_height, out_item.box_width, out_item.center_y, out_item.center_x};

endmodule
